// ----- hdl/wvs_pkg.sv -----
package wvs_pkg;

  localparam int SLOTS       = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int SLOT_BITS   = $clog2(SLOTS);
  localparam int CNT_BITS    = $clog2(SLOTS + 1);
  // largest running sum is SLOTS * (2**WEIGHT_BITS - 1)
  localparam int SUM_BITS    = WEIGHT_BITS + SLOT_BITS;
  localparam int VALUE_BITS  = 64;
  // quotient bits retired per cycle by the remainder unit
  localparam int REM_DIGIT   = 2;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_REBUILD = 2'd1;
  localparam logic [1:0] KIND_PICK    = 2'd2;

  typedef struct packed {
    logic [1:0]             kind;
    logic [SLOT_BITS-1:0]   slot;
    logic [WEIGHT_BITS-1:0] weight;
    logic                   connected;
    logic [VALUE_BITS-1:0]  pick_value;
  } req_t;

  typedef struct packed {
    logic                 found;
    logic [SLOT_BITS-1:0] chosen_slot;
    logic [CNT_BITS-1:0]  active_count;
  } rsp_t;

endpackage

// ----- hdl/wvs_rem.sv -----
module wvs_rem (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wvs_pkg::VALUE_BITS-1:0] dividend,
  input  logic [wvs_pkg::SUM_BITS-1:0]   divisor,
  output logic                          done,
  output logic [wvs_pkg::SUM_BITS-1:0]   rem
);
  import wvs_pkg::*;

  localparam int STEPS     = VALUE_BITS / REM_DIGIT;
  localparam int STEP_BITS = $clog2(STEPS);

  logic                  busy;
  logic [STEP_BITS-1:0]  cnt;
  logic [VALUE_BITS-1:0] shreg;
  logic [SUM_BITS-1:0]   dvs;
  logic [SUM_BITS-1:0]   rem_next;

  // one restoring step: shift in a dividend bit, subtract if it fits
  function automatic logic [SUM_BITS-1:0] rem_step(input logic [SUM_BITS-1:0] r,
                                                   input logic                b,
                                                   input logic [SUM_BITS-1:0] d);
    logic [SUM_BITS:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[SUM_BITS-1:0];
  endfunction

  always_comb begin
    rem_next = rem;
    for (int i = 0; i < REM_DIGIT; i++) begin
      rem_next = rem_step(rem_next, shreg[VALUE_BITS-1-i], dvs);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        shreg <= dividend;
        dvs   <= divisor;
        rem   <= '0;
      end else if (busy) begin
        rem   <= rem_next;
        shreg <= shreg << REM_DIGIT;
        cnt   <= cnt + 1'b1;
        if (cnt == STEP_BITS'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> rem < dvs)
    else $error("remainder not below divisor");

endmodule

// ----- hdl/weighted_valid_select_top.sv -----
// Weighted target selector over 16 slots. A write word sets one slot's weight and
// connected flag and answers through ST_DONE. A rebuild word walks the slots one
// per cycle, packing connected ones into the active list with running weight sums.
// A pick word reduces pick_value modulo the total weight in a bit-serial remainder
// unit retiring 2 bits per cycle, then walks the active list one entry per cycle
// to find the first running sum above the remainder, then scans circularly for a
// slot that is still connected. An empty list or zero total answers not-found
// without the remainder unit or the walks. One word is in work at a time; the next
// is taken while a finished result still waits on rsp.
module weighted_valid_select_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  wvs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output wvs_pkg::rsp_t rsp
);
  import wvs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_BUILD  = 6'b000010,
    ST_DIV    = 6'b000100,
    ST_SEARCH = 6'b001000,
    ST_SCAN   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state;

  logic [WEIGHT_BITS-1:0] slot_weight [SLOTS];
  logic [SLOTS-1:0]       slot_connected;
  logic [SLOT_BITS-1:0]   active_slot [SLOTS];
  logic [SUM_BITS-1:0]    running_sum [SLOTS];
  logic [CNT_BITS-1:0]    active_len;
  logic [SUM_BITS-1:0]    total;

  logic [SLOT_BITS-1:0]   idx;
  logic [CNT_BITS-1:0]    build_n;
  logic [SUM_BITS-1:0]    acc;
  logic [CNT_BITS-1:0]    scan_cnt;
  rsp_t                   res;

  logic                   accept;
  logic                   rem_start;
  logic                   rem_done;
  logic [SUM_BITS-1:0]    rem_val;
  logic                   cur_conn;
  logic [SUM_BITS-1:0]    sum_add;
  logic [CNT_BITS-1:0]    build_n_inc;
  logic                   last_slot;
  logic [CNT_BITS-1:0]    len_last;
  logic                   at_last;
  logic [SLOT_BITS-1:0]   idx_wrap;
  logic [SLOT_BITS-1:0]   scan_slot;
  logic                   pick_empty;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;

  assign cur_conn    = slot_connected[idx];
  assign sum_add     = acc + SUM_BITS'(slot_weight[idx]);
  assign build_n_inc = build_n + CNT_BITS'(cur_conn);
  assign last_slot   = (idx == SLOT_BITS'(SLOTS - 1));
  assign len_last    = active_len - 1'b1;
  assign at_last     = (CNT_BITS'(idx) == len_last);
  assign idx_wrap    = at_last ? '0 : idx + 1'b1;
  assign scan_slot   = active_slot[idx];
  assign pick_empty  = (active_len == '0) || (total == '0);
  assign rem_start   = accept && (req.kind == KIND_PICK) && !pick_empty;

  wvs_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (req.pick_value),
    .divisor  (total),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // slot weights and the active list: no reset, weights only read for
  // connected slots, list entries only read below active_len
  always_ff @(posedge clk) begin
    if (accept && req.kind == KIND_WRITE) begin
      slot_weight[req.slot] <= req.weight;
    end
    if (state == ST_BUILD && cur_conn) begin
      active_slot[build_n[SLOT_BITS-1:0]] <= idx;
      running_sum[build_n[SLOT_BITS-1:0]] <= sum_add;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      slot_connected <= '0;
      active_len     <= '0;
      total          <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      // ST_DONE reloads the output itself
      if (rsp_valid && !rsp_stall && state != ST_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res <= '{found: 1'b0, chosen_slot: '0, active_count: active_len};
            unique case (req.kind)
              KIND_WRITE: begin
                slot_connected[req.slot] <= req.connected;
                state <= ST_DONE;
              end
              KIND_REBUILD: begin
                idx     <= '0;
                build_n <= '0;
                acc     <= '0;
                state   <= ST_BUILD;
              end
              KIND_PICK: begin
                state <= pick_empty ? ST_DONE : ST_DIV;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_BUILD: begin
          if (cur_conn) begin
            acc <= sum_add;
          end
          build_n <= build_n_inc;
          idx     <= idx + 1'b1;
          if (last_slot) begin
            active_len <= build_n_inc;
            total      <= cur_conn ? sum_add : acc;
            res        <= '{found: 1'b0, chosen_slot: '0, active_count: build_n_inc};
            state      <= ST_DONE;
          end
        end
        ST_DIV: begin
          if (rem_done) begin
            idx   <= '0;
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          // running sums never decrease, so the first one above rem is the start
          if (running_sum[idx] > rem_val) begin
            scan_cnt <= '0;
            state    <= ST_SCAN;
          end else if (at_last) begin
            state <= ST_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_SCAN: begin
          // list may be stale: check the slot's current flag
          if (slot_connected[scan_slot]) begin
            res   <= '{found: 1'b1, chosen_slot: scan_slot, active_count: active_len};
            state <= ST_DONE;
          end else if (scan_cnt == len_last) begin
            state <= ST_DONE;
          end else begin
            idx      <= idx_wrap;
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_notfound_zero_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.chosen_slot == '0)
    else $error("not-found word carries a slot");

  a_div_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> active_len != '0 && total != '0)
    else $error("remainder started on empty list or zero total");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> scan_cnt < active_len && CNT_BITS'(idx) < active_len)
    else $error("scan beyond active list");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.active_count <= CNT_BITS'(SLOTS))
    else $error("active count out of range");

endmodule

// ----- tb/sv/tb_weighted_valid_select_top.sv -----
module tb_weighted_valid_select_top;
  import wvs_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [WEIGHT_BITS-1:0] W_MAX = {WEIGHT_BITS{1'b1}};
  localparam int CMD_TOTAL   = 440;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 100;
  localparam int HOLD_AT     = 60;
  localparam int HOLD_LEN    = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_word = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_word;

  weighted_valid_select_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  req_t cmd_queue[$];
  rsp_t answer_queue[$];
  int   sent_count = 0;
  int   errors = 0;
  int   cycle_count = 0;
  int   gap_left = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  rsp_t want;

  // selector state as the block should hold it
  logic [WEIGHT_BITS-1:0] tbl_weight [SLOTS];
  logic                   tbl_conn   [SLOTS];
  logic [SLOT_BITS-1:0]   list_slot  [SLOTS];
  logic [SUM_BITS-1:0]    list_sum   [SLOTS];
  int                     list_len;

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      tbl_weight[s] = '0;
      tbl_conn[s]   = 1'b0;
    end
    list_len = 0;
  end

  function automatic rsp_t predict_answer(req_t w);
    rsp_t a;
    logic [SUM_BITS-1:0] acc;
    logic [SUM_BITS-1:0] total;
    logic [63:0] remv;
    int n;
    int start;
    int e;
    a = '0;
    case (w.kind)
      KIND_WRITE: begin
        tbl_weight[w.slot] = w.weight;
        tbl_conn[w.slot]   = w.connected;
      end
      KIND_REBUILD: begin
        acc = '0;
        n = 0;
        for (int s = 0; s < SLOTS; s++) begin
          if (tbl_conn[s]) begin
            acc = acc + SUM_BITS'(tbl_weight[s]);
            list_slot[n] = SLOT_BITS'(s);
            list_sum[n]  = acc;
            n++;
          end
        end
        list_len = n;
      end
      KIND_PICK: begin
        if (list_len != 0) begin
          total = list_sum[list_len-1];
          if (total != 0) begin
            remv = w.pick_value % 64'(total);
            start = 0;
            while (start < list_len && 64'(list_sum[start]) <= remv) start++;
            // scan from the hit entry, wrapping, for a slot still connected
            for (int i = 0; i < list_len && !a.found; i++) begin
              e = (start + i) % list_len;
              if (tbl_conn[list_slot[e]]) begin
                a.found = 1'b1;
                a.chosen_slot = list_slot[e];
              end
            end
          end
        end
      end
      default: ;
    endcase
    a.active_count = CNT_BITS'(list_len);
    return a;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void add_cmd(logic [1:0] k, int s, logic [WEIGHT_BITS-1:0] w,
                                  logic c, logic [63:0] v);
    req_t cmd;
    cmd.kind       = k;
    cmd.slot       = SLOT_BITS'(s);
    cmd.weight     = w;
    cmd.connected  = c;
    cmd.pick_value = v;
    cmd_queue.insert(cmd_queue.size(), cmd);
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] draw_weight();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return W_MAX;
    if (r < 5) return WEIGHT_BITS'($urandom_range(1, 8));
    return WEIGHT_BITS'($urandom);
  endfunction

  function automatic logic [63:0] draw_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 4) return 64'($urandom_range(0, 300));
    return rand64();
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic quiet_window(int n);
    return n >= 200 && n < 260;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left  <= 0;
    end else begin
      if (req_valid && !req_stall) begin
        answer_queue.insert(answer_queue.size(), predict_answer(req_word));
        sent_count <= sent_count + 1;
      end
      if (!req_valid || !req_stall) begin
        if (gap_left != 0) begin
          req_valid <= 1'b0;
          gap_left  <= gap_left - 1;
        end else if (cmd_queue.size() != 0) begin
          req_valid <= 1'b1;
          req_word  <= cmd_queue.pop_front();
          gap_left  <= quiet_window(sent_count) ? 0 : draw_gap();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall; one long hold-off lets the block back up into its input
  always @(posedge clk) begin
    int r;
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_count >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      rsp_stall <= 1'b1;
    end else if (quiet_window(sent_count)) begin
      rsp_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        rsp_stall <= 1'b0;
      end else if (r < 96) begin
        rsp_stall <= 1'b1;
        hold_left <= $urandom_range(0, 3);
      end else begin
        rsp_stall <= 1'b1;
        hold_left <= $urandom_range(20, 120);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (answer_queue.size() == 0) begin
        $error("unexpected result word: found %0d chosen_slot %0d active_count %0d",
               rsp_word.found, rsp_word.chosen_slot, rsp_word.active_count);
        errors++;
      end else begin
        want = answer_queue.pop_front();
        if (rsp_word.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, rsp_word.found);
          errors++;
        end
        if (rsp_word.chosen_slot !== want.chosen_slot) begin
          $error("chosen_slot: expected %0d, got %0d", want.chosen_slot, rsp_word.chosen_slot);
          errors++;
        end
        if (rsp_word.active_count !== want.active_count) begin
          $error("active_count: expected %0d, got %0d",
                 want.active_count, rsp_word.active_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_weighted_valid_select_top failed");
      $finish;
    end
  end

  initial begin
    int r;
    int n;
    // empty list, before and after a rebuild of an all-disconnected table
    add_cmd(KIND_PICK, 0, '0, 1'b0, 64'd5);
    add_cmd(KIND_REBUILD, 0, '0, 1'b0, '0);
    add_cmd(KIND_PICK, 15, W_MAX, 1'b1, '1);
    add_cmd(KIND_UNUSED, 9, W_MAX, 1'b1, '1);
    // connected but zero total weight
    add_cmd(KIND_WRITE, 0, '0, 1'b1, '0);
    add_cmd(KIND_WRITE, 15, '0, 1'b1, '0);
    add_cmd(KIND_REBUILD, 3, 16'h1234, 1'b0, '0);
    add_cmd(KIND_PICK, 0, '0, 1'b0, '1);
    // max weights at both ends, weight 1 in the middle
    add_cmd(KIND_WRITE, 0, W_MAX, 1'b1, '0);
    add_cmd(KIND_WRITE, 15, W_MAX, 1'b1, '1);
    add_cmd(KIND_WRITE, 7, 16'd1, 1'b1, '0);
    add_cmd(KIND_REBUILD, 0, '0, 1'b0, '0);
    add_cmd(KIND_PICK, 0, '0, 1'b0, 64'd0);
    add_cmd(KIND_PICK, 0, '0, 1'b0, '1);
    add_cmd(KIND_PICK, 0, '0, 1'b0, 64'd65535);
    // stale list: slot 7 drops out, scan moves on to the next connected one
    add_cmd(KIND_WRITE, 7, 16'd1, 1'b0, '0);
    add_cmd(KIND_PICK, 0, '0, 1'b0, 64'd65535);
    add_cmd(KIND_WRITE, 15, W_MAX, 1'b0, '0);
    add_cmd(KIND_WRITE, 0, W_MAX, 1'b0, '0);
    add_cmd(KIND_PICK, 0, '0, 1'b0, 64'd65535);
    add_cmd(KIND_UNUSED, 0, '0, 1'b0, '0);

    while (cmd_queue.size() < CMD_TOTAL) begin
      r = $urandom_range(0, 19);
      if (r == 0 || r == 1) begin
        // full table: all max weight connected, or everything disconnected
        for (int s = 0; s < SLOTS; s++)
          add_cmd(KIND_WRITE, s, (r == 0) ? W_MAX : draw_weight(), r == 0, rand64());
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          add_cmd(KIND_WRITE, $urandom_range(0, SLOTS-1), draw_weight(),
                  $urandom_range(0, 3) != 0, rand64());
      end
      if ($urandom_range(0, 9) != 0)
        add_cmd(KIND_REBUILD, $urandom_range(0, SLOTS-1), WEIGHT_BITS'($urandom),
                1'($urandom_range(0, 1)), rand64());
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 5) == 0)
          add_cmd(KIND_WRITE, $urandom_range(0, SLOTS-1), draw_weight(), 1'b0, rand64());
        add_cmd(KIND_PICK, $urandom_range(0, SLOTS-1), WEIGHT_BITS'($urandom),
                1'($urandom_range(0, 1)), draw_value());
      end
      if ($urandom_range(0, 14) == 0)
        add_cmd(KIND_UNUSED, $urandom_range(0, SLOTS-1), WEIGHT_BITS'($urandom),
                1'($urandom_range(0, 1)), rand64());
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() != 0 || req_valid) @(posedge clk);
    while (answer_queue.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb_weighted_valid_select_top passed");
    else
      $display("tb_weighted_valid_select_top failed");
    $finish;
  end

endmodule
